// ===== design/svpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared widths, constants, types and format helpers of the svpwm duty core
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // fraction bits of the internal duty format
    localparam int FRAC_BITS  = 15;
    localparam int QW         = FRAC_BITS + 1;          // holds 0 .. 2^F and sums below 2^(F+1)
    localparam int IN_W       = 16;                      // q1.15 reference width
    localparam int MAG_W      = IN_W + 1;                // magnitude 0 .. 32768
    localparam int RECIP_W    = 30;
    localparam int PERIOD_W   = 16;
    localparam int OUT_W      = 16;
    localparam int SCALE_W    = 16;
    localparam int SECTOR_W   = 3;
    localparam int DIV_STAGES = FRAC_BITS;               // one quotient bit per stage

    // format conversion shifts between q.15 and q.F
    localparam int UP_SH = (FRAC_BITS >= 15) ? (FRAC_BITS - 15) : 0;
    localparam int DN_SH = (FRAC_BITS >= 15) ? 0 : (15 - FRAC_BITS);

    localparam logic [RECIP_W-1:0]  RECIP_SQRT3_Q30 = 30'd619925131;  // floor(2^30 / sqrt3)
    localparam logic [QW-1:0]       ONE_Q           = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SCALE_W-1:0]  SCALE_ONE       = 16'd32768;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd1000;

    // stream packing
    localparam int IN_DATA_W  = 2 * IN_W;
    localparam int OUT_PACK_W = 3 * OUT_W + SECTOR_W + SCALE_W;
    localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 1;

    typedef enum logic [SECTOR_W-1:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } t_sector;

    // sector, active times and their sum
    typedef struct packed {
        t_sector        sector;
        logic           clip;
        logic [QW-1:0]  tx;
        logic [QW-1:0]  ty;
        logic [QW-1:0]  s;
    } t_mid;

    // the same plus the reciprocal scale k = 2^(2F) / s
    typedef struct packed {
        t_mid                 mid;
        logic [FRAC_BITS-1:0] kq;
    } t_div;

    typedef struct packed {
        logic [OUT_W-1:0]   on_a;
        logic [OUT_W-1:0]   on_b;
        logic [OUT_W-1:0]   on_c;
        t_sector            sector;
        logic               clip;
        logic [SCALE_W-1:0] scale;
    } t_result;

    function automatic logic [QW-1:0] q15_to_qf(input logic [MAG_W-1:0] m);
        logic [MAG_W+FRAC_BITS-1:0] w;
        w = {{FRAC_BITS{1'b0}}, m};
        w = (w << UP_SH) >> DN_SH;
        return w[QW-1:0];
    endfunction

    function automatic logic [SCALE_W-1:0] qf_to_q15(input logic [FRAC_BITS-1:0] v);
        logic [SCALE_W+FRAC_BITS-1:0] w;
        w = {{SCALE_W{1'b0}}, v};
        w = (w << DN_SH) >> UP_SH;
        return w[SCALE_W-1:0];
    endfunction

endpackage

// ===== design/svpwm_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_sector
// three stage front end: magnitudes, |beta|/sqrt3, sector and active times
// ----------------------------------------------------------------------------
module svpwm_sector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [svpwm_pkg::IN_W-1:0] i_alpha,
    input  logic signed [svpwm_pkg::IN_W-1:0] i_beta,
    output logic                           o_valid,
    input  logic                           i_ready,
    output svpwm_pkg::t_mid                o_mid
);
    import svpwm_pkg::*;

    logic en0, en1, en2;
    logic r_v0, r_v1, r_v2;

    // stage 0: signs and magnitudes in q.F
    logic             r0_aneg, r0_bneg;
    logic [QW-1:0]    r0_aq, r0_bq;
    logic [MAG_W-1:0] a_ext, b_ext, a_mag, b_mag;

    // stage 1: |beta|/sqrt3
    logic             r1_aneg, r1_bneg;
    logic [QW-1:0]    r1_aq, r1_b3;
    logic [QW+RECIP_W-1:0] b3_prod;

    // stage 2: sector and times
    t_mid          r2_mid, n_mid;
    logic          middle;
    logic [QW-1:0] b3x2;

    assign en2     = ~r_v2 | i_ready;
    assign en1     = ~r_v1 | en2;
    assign en0     = ~r_v0 | en1;
    assign o_ready = en0;

    assign a_ext = {i_alpha[IN_W-1], i_alpha};
    assign b_ext = {i_beta[IN_W-1], i_beta};
    assign a_mag = i_alpha[IN_W-1] ? (MAG_W'(0) - a_ext) : a_ext;
    assign b_mag = i_beta[IN_W-1]  ? (MAG_W'(0) - b_ext) : b_ext;

    assign b3_prod = r0_bq * RECIP_SQRT3_Q30;

    assign middle = r1_aq < r1_b3;
    assign b3x2   = {r1_b3[QW-2:0], 1'b0};

    always_comb begin
        n_mid.clip = 1'b0;
        if (middle) begin
            n_mid.sector = r1_bneg ? SEC_5 : SEC_2;
            if (r1_aneg) begin
                n_mid.tx = r1_b3 - r1_aq;
                n_mid.ty = r1_b3 + r1_aq;
            end else begin
                n_mid.tx = r1_b3 + r1_aq;
                n_mid.ty = r1_b3 - r1_aq;
            end
        end else begin
            if (r1_bneg) begin
                n_mid.sector = r1_aneg ? SEC_4 : SEC_6;
            end else begin
                n_mid.sector = r1_aneg ? SEC_3 : SEC_1;
            end
            n_mid.tx = r1_aq - r1_b3;
            n_mid.ty = b3x2;
        end
        n_mid.s    = n_mid.tx + n_mid.ty;
        n_mid.clip = n_mid.s > ONE_Q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_aneg <= i_alpha[IN_W-1];
            r0_bneg <= i_beta[IN_W-1];
            r0_aq   <= q15_to_qf(a_mag);
            r0_bq   <= q15_to_qf(b_mag);
        end
        if (en1) begin
            r1_aneg <= r0_aneg;
            r1_bneg <= r0_bneg;
            r1_aq   <= r0_aq;
            r1_b3   <= b3_prod[QW+RECIP_W-1:RECIP_W];
        end
        if (en2) begin
            r2_mid <= n_mid;
        end
    end

    assign o_valid = r_v2;
    assign o_mid   = r2_mid;

endmodule

// ===== design/svpwm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_div
// restoring divider pipeline for k = 2^(2F) / s, one quotient bit per stage
// ----------------------------------------------------------------------------
module svpwm_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpwm_pkg::t_mid i_mid,
    output logic            o_valid,
    input  logic            i_ready,
    output svpwm_pkg::t_div o_div
);
    import svpwm_pkg::*;

    logic                 en    [DIV_STAGES+1];
    logic                 r_v   [DIV_STAGES];
    t_mid                 r_mid [DIV_STAGES];
    logic [QW-1:0]        r_rem [DIV_STAGES];
    logic [FRAC_BITS-1:0] r_q   [DIV_STAGES];

    assign en[DIV_STAGES] = i_ready;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                 v_in;
        t_mid                 mid_in;
        logic [QW-1:0]        rem_in;
        logic [FRAC_BITS-1:0] q_in;
        logic [QW:0]          trial, s_ext, diff;
        logic                 ge;
        logic [QW-1:0]        n_rem;
        logic [FRAC_BITS-1:0] n_q;

        if (k == 0) begin : g_first
            // 2^(2F) / s starts from a partial remainder of 2^F
            assign v_in   = i_valid;
            assign mid_in = i_mid;
            assign rem_in = ONE_Q;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign mid_in = r_mid[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
        end

        assign en[k] = ~r_v[k] | en[k+1];

        assign trial = {rem_in, 1'b0};
        assign s_ext = {1'b0, mid_in.s};
        assign ge    = trial >= s_ext;
        assign diff  = trial - s_ext;
        assign n_rem = ge ? diff[QW-1:0] : trial[QW-1:0];
        assign n_q   = {q_in[FRAC_BITS-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_mid[k] <= mid_in;
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
            end
        end
    end

    assign o_ready   = en[0];
    assign o_valid   = r_v[DIV_STAGES-1];
    assign o_div.mid = r_mid[DIV_STAGES-1];
    assign o_div.kq  = r_q[DIV_STAGES-1];

endmodule

// ===== design/svpwm_duty.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_duty
// three stage back end: clip scaling, phase fractions, on-time multiply
// ----------------------------------------------------------------------------
module svpwm_duty (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [svpwm_pkg::PERIOD_W-1:0]   i_period,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  svpwm_pkg::t_div                  i_div,
    output logic                             o_valid,
    input  logic                             i_ready,
    output svpwm_pkg::t_result               o_res
);
    import svpwm_pkg::*;

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    // stage 1: scaled active times and zero time
    logic [QW+FRAC_BITS-1:0] px, py;
    logic [QW-1:0]      r1_tx, r1_ty, r1_t0;
    logic [QW-1:0]      n1_tx, n1_ty, n1_t0;
    logic [SCALE_W-1:0] n1_scale, r1_scale;
    t_sector            r1_sector;
    logic               r1_clip;

    // stage 2: phase fractions
    logic [QW-1:0]      h, full;
    logic [QW-1:0]      n2_fa, n2_fb, n2_fc;
    logic [QW-1:0]      r2_fa, r2_fb, r2_fc;
    t_sector            r2_sector;
    logic               r2_clip;
    logic [SCALE_W-1:0] r2_scale;

    // stage 3: on-times
    logic [PERIOD_W+QW-1:0] pa, pb, pc;
    t_result                r3_res;

    assign en3     = ~r_v3 | i_ready;
    assign en2     = ~r_v2 | en3;
    assign en1     = ~r_v1 | en2;
    assign o_ready = en1;

    assign px = i_div.mid.tx * i_div.kq;
    assign py = i_div.mid.ty * i_div.kq;

    always_comb begin
        if (i_div.mid.clip) begin
            n1_tx    = px[QW+FRAC_BITS-1:FRAC_BITS];
            n1_ty    = py[QW+FRAC_BITS-1:FRAC_BITS];
            n1_t0    = '0;
            n1_scale = qf_to_q15(i_div.kq);
        end else begin
            n1_tx    = i_div.mid.tx;
            n1_ty    = i_div.mid.ty;
            n1_t0    = ONE_Q - i_div.mid.s;
            n1_scale = SCALE_ONE;
        end
    end

    assign h    = r1_t0 >> 1;
    assign full = r1_tx + r1_ty + h;

    always_comb begin
        case (r1_sector)
            SEC_1: begin
                n2_fa = full;       n2_fb = r1_ty + h;  n2_fc = h;
            end
            SEC_2: begin
                n2_fa = r1_tx + h;  n2_fb = full;       n2_fc = h;
            end
            SEC_3: begin
                n2_fa = h;          n2_fb = full;       n2_fc = r1_tx + h;
            end
            SEC_4: begin
                n2_fa = h;          n2_fb = r1_tx + h;  n2_fc = full;
            end
            SEC_5: begin
                n2_fa = r1_tx + h;  n2_fb = h;          n2_fc = full;
            end
            default: begin
                n2_fa = full;       n2_fb = h;          n2_fc = r1_ty + h;
            end
        endcase
    end

    assign pa = i_period * r2_fa;
    assign pb = i_period * r2_fb;
    assign pc = i_period * r2_fc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_tx     <= n1_tx;
            r1_ty     <= n1_ty;
            r1_t0     <= n1_t0;
            r1_scale  <= n1_scale;
            r1_sector <= i_div.mid.sector;
            r1_clip   <= i_div.mid.clip;
        end
        if (en2) begin
            r2_fa     <= n2_fa;
            r2_fb     <= n2_fb;
            r2_fc     <= n2_fc;
            r2_sector <= r1_sector;
            r2_clip   <= r1_clip;
            r2_scale  <= r1_scale;
        end
        if (en3) begin
            r3_res.on_a   <= pa[FRAC_BITS+OUT_W-1:FRAC_BITS];
            r3_res.on_b   <= pb[FRAC_BITS+OUT_W-1:FRAC_BITS];
            r3_res.on_c   <= pc[FRAC_BITS+OUT_W-1:FRAC_BITS];
            r3_res.sector <= r2_sector;
            r3_res.clip   <= r2_clip;
            r3_res.scale  <= r2_scale;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r3_res;

    // no phase fraction may pass one full period
    a_frac_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r2_fa <= ONE_Q) && (r2_fb <= ONE_Q) && (r2_fc <= ONE_Q))
        else $error("phase fraction above one period");

    // unclipped results carry unity scale
    a_scale_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r3_res.clip |-> r3_res.scale == SCALE_ONE)
        else $error("unity scale missing on unclipped result");

    // clipped results always shrink
    a_scale_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r3_res.clip |-> r3_res.scale < SCALE_ONE)
        else $error("clip scale not below one");

endmodule

// ===== design/space_vector_pwm_duty_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core
// symmetric space vector pwm duty calculator, alpha-beta in, on-times out
// ----------------------------------------------------------------------------
// usage:
//  - slave stream takes one alpha-beta reference request per transfer
//    (q1.15 each); master stream returns one result per request, in order
//  - result: phase a/b/c on-times in timer counts, sector 1..6, clip
//    scale k (q.15), and the clip flag in tuser
//  - pwm_period is written through i_cfg_wr_en / i_cfg_wr_data while no
//    request is in flight; it is read live by the on-time multiply
//  - 21 register stages: 3 front-end (magnitude, 1/sqrt3 multiply, sector),
//    15 divider stages (one quotient bit each), 3 back-end (scale,
//    fractions, on-time)
//  - throughput one request per cycle while the master takes results, as the divider is fully pipelined
//  - every stage has its own valid bit and moves whenever the stage after
//    it is empty or moving, so bubbles collapse; a stalled master only
//    backs up the pipe once all 21 stages hold a request, nothing is lost
//  - synchronous active-low reset empties the pipe and loads pwm_period
//    with 1000; no memory, so no clearing pass
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [svpwm_pkg::PERIOD_W-1:0]    i_cfg_wr_data,    // pwm_period
    // reference requests
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [svpwm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,   // alpha_ref, beta_ref
    // results
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [svpwm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,   // on_time_a, on_time_b,
                                                                // on_time_c, sector,
                                                                // clip_scale, zero pad
    output logic [svpwm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser    // clipped
);
    import svpwm_pkg::*;

    logic [PERIOD_W-1:0] r_pwm_period;

    // front end to divider
    logic mid_valid, mid_ready;
    t_mid mid;

    // divider to back end
    logic div_valid, div_ready;
    t_div div_res;

    t_result res;

    // period register; the user must write it only while the pipe is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_pwm_period <= i_cfg_wr_data;
        end
    end

    svpwm_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_alpha ($signed(i_s_axis_tdata[IN_W-1:0])),
        .i_beta  ($signed(i_s_axis_tdata[2*IN_W-1:IN_W])),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    // k = 2^(2F) / (tx + ty), only used when the sum overruns one period
    svpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_div   (div_res)
    );

    svpwm_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_period (r_pwm_period),
        .i_valid  (div_valid),
        .o_ready  (div_ready),
        .i_div    (div_res),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_res    (res)
    );

    // pack result fields from the lowest bit up
    assign o_m_axis_tdata = {{(OUT_DATA_W-OUT_PACK_W){1'b0}},
                             res.scale, res.sector, res.on_c, res.on_b, res.on_a};
    assign o_m_axis_tuser = res.clip;

    // an empty output stage means every stage can move, so requests flow in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

endmodule
